// ----- sv/fpfp_pkg.sv -----
package fpfp_pkg;

    localparam int MAX_COMMAND_WORDS = 4;
    localparam int WORD_BYTES        = 5;
    localparam int SRC_START         = 16;
    localparam int DST_START         = 20;
    localparam int PORT_START        = 24;
    localparam int CODE_START        = 26;
    localparam int CMD_START         = 28;
    localparam int CMD_END           = CMD_START + WORD_BYTES * MAX_COMMAND_WORDS;
    localparam int POS_W             = $clog2(CMD_END + 1);

    localparam logic [7:0] CODE_STOP   = 8'h00;
    localparam logic [7:0] CODE_SERIAL = 8'h01;
    localparam logic [7:0] CODE_TIME   = 8'h02;
    localparam logic [7:0] CODE_ROUTE  = 8'h3F;

    localparam logic [2:0] LAST_PHASE = 3'(WORD_BYTES - 1);

    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [15:0] command_code;
        logic [31:0] serial_number;
        logic [31:0] first_packet_time;
        logic [31:0] route_ip;
    } t_fields;

endpackage

// ----- sv/fpfp_in_if.sv -----
interface fpfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

// ----- sv/fpfp_out_if.sv -----
interface fpfp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [15:0] command_code;
    logic [31:0] serial_number;
    logic [1:0]  instrument_type;
    logic [31:0] first_packet_time;
    logic [31:0] route_ip;

    modport source (
        output valid, source_ip, dest_ip, dest_port, command_code, serial_number,
               instrument_type, first_packet_time, route_ip,
        input  ready
    );
    modport sink (
        input  valid, source_ip, dest_ip, dest_port, command_code, serial_number,
               instrument_type, first_packet_time, route_ip,
        output ready
    );
endinterface

// ----- sv/fpfp_parse.sv -----
module fpfp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    output fpfp_pkg::t_fields o_fields
);
    import fpfp_pkg::*;

    t_pos        r_pos,    n_pos;
    logic [2:0]  r_phase,  n_phase;
    logic        r_done,   n_done;
    logic [7:0]  r_code,   n_code;
    logic [31:0] r_value,  n_value;
    t_fields     r_fields, n_fields;

    logic        in_cmd;
    logic [1:0]  lane;

    always_comb begin
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_done   = r_done;
        n_code   = r_code;
        n_value  = r_value;
        n_fields = r_fields;
        in_cmd   = (r_pos >= t_pos'(CMD_START)) && (r_pos < t_pos'(CMD_END));
        lane     = 2'(r_phase - 3'd1);

        if (r_pos >= t_pos'(SRC_START) && r_pos < t_pos'(DST_START)) begin
            n_fields.source_ip[{r_pos[1:0], 3'b000} +: 8] =
                r_fields.source_ip[{r_pos[1:0], 3'b000} +: 8] | i_byte;
        end else if (r_pos >= t_pos'(DST_START) && r_pos < t_pos'(PORT_START)) begin
            n_fields.dest_ip[{r_pos[1:0], 3'b000} +: 8] =
                r_fields.dest_ip[{r_pos[1:0], 3'b000} +: 8] | i_byte;
        end else if (r_pos >= t_pos'(PORT_START) && r_pos < t_pos'(CODE_START)) begin
            n_fields.dest_port[{r_pos[0], 3'b000} +: 8] =
                r_fields.dest_port[{r_pos[0], 3'b000} +: 8] | i_byte;
        end else if (r_pos >= t_pos'(CODE_START) && r_pos < t_pos'(CMD_START)) begin
            n_fields.command_code[{r_pos[0], 3'b000} +: 8] =
                r_fields.command_code[{r_pos[0], 3'b000} +: 8] | i_byte;
        end else if (in_cmd && !r_done) begin
            if (r_phase == 3'd0) begin
                n_code  = i_byte;
                n_value = '0;
                if (i_byte == CODE_STOP) begin
                    n_done = 1'b1;
                end
            end else begin
                n_value[{lane, 3'b000} +: 8] = r_value[{lane, 3'b000} +: 8] | i_byte;
                if (r_phase == LAST_PHASE) begin
                    case (r_code)
                        CODE_SERIAL: n_fields.serial_number     = n_value;
                        CODE_TIME:   n_fields.first_packet_time = n_value;
                        CODE_ROUTE:  n_fields.route_ip          = n_value;
                        default: ;
                    endcase
                end
            end
        end

        // word phase tracks the position even after the stop code
        if (in_cmd) begin
            n_phase = (r_phase == LAST_PHASE) ? 3'd0 : r_phase + 3'd1;
        end

        if (r_pos < t_pos'(CMD_END)) begin
            n_pos = r_pos + t_pos'(1);
        end
    end

    assign o_fields = n_fields;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_phase  <= '0;
            r_done   <= 1'b0;
            r_code   <= '0;
            r_value  <= '0;
            r_fields <= '0;
        end else if (i_step) begin
            if (i_end) begin
                r_pos    <= '0;
                r_phase  <= '0;
                r_done   <= 1'b0;
                r_code   <= '0;
                r_value  <= '0;
                r_fields <= '0;
            end else begin
                r_pos    <= n_pos;
                r_phase  <= n_phase;
                r_done   <= n_done;
                r_code   <= n_code;
                r_value  <= n_value;
                r_fields <= n_fields;
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= t_pos'(CMD_END))
        else $error("byte position beyond command area");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= LAST_PHASE)
        else $error("word phase out of range");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_end |=> r_pos == '0 && !r_done && r_fields == '0)
        else $error("parser not cleared after last byte");
`endif

endmodule

// ----- sv/first_packet_frame_parser.sv -----
// First-packet frame parser.
// i_frame: one frame byte per transfer, frame_end high on the last byte.
// o_result: one transfer per frame, carrying the header fields (source IP,
//   destination IP and port, command number) and the values of the last
//   complete serial, first-packet-time and route command words.
// A byte enters an input register and is parsed from there; on the last byte
// the collected fields land in the result register once that register is
// free, and o_result.valid is driven from that register.
// Throughput is one byte per cycle while no last byte waits on a full result
// register; frames may follow each other without gaps.
// When the receiver stalls, the result waits in its register and bytes keep
// flowing; only a last byte holds in the input register until the result
// register frees, and i_frame.ready is low while it holds.
// Synchronous active-low reset empties both registers and clears the parser,
// which starts at byte offset zero.
module first_packet_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpfp_in_if.sink     i_frame,
    fpfp_out_if.source  o_result
);
    import fpfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_out_valid;
    t_fields    r_out_fields;

    logic       out_free;
    logic       consume;
    t_fields    fields;

    assign out_free = !r_out_valid || o_result.ready;
    assign consume  = r_in_valid && (!r_in_end || out_free);
    assign i_frame.ready = !r_in_valid || consume;

    fpfp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (consume),
        .i_byte   (r_in_byte),
        .i_end    (r_in_end),
        .o_fields (fields)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.ready && i_frame.valid) begin
            r_in_byte <= i_frame.frame_byte;
            r_in_end  <= i_frame.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_in_end) begin
            r_out_fields <= fields;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.source_ip         = r_out_fields.source_ip;
    assign o_result.dest_ip           = r_out_fields.dest_ip;
    assign o_result.dest_port         = r_out_fields.dest_port;
    assign o_result.command_code      = r_out_fields.command_code;
    assign o_result.serial_number     = r_out_fields.serial_number;
    assign o_result.instrument_type   = r_out_fields.serial_number[1:0];
    assign o_result.first_packet_time = r_out_fields.first_packet_time;
    assign o_result.route_ip          = r_out_fields.route_ip;

`ifndef SYNTHESIS
    a_last_byte_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_end && r_out_valid && !o_result.ready
        |=> r_in_valid && r_in_end && $stable(r_in_byte))
        else $error("last byte dropped while result register full");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in_end |=> r_out_valid)
        else $error("last byte produced no result");

    a_mid_byte_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_in_end |-> i_frame.ready)
        else $error("input stalled on a non-final byte");
`endif

endmodule

// ----- bench/tb_first_packet_frame_parser.sv -----
module tb_first_packet_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 960;
    localparam int MIN_FRAMES   = 10;
    localparam int LONG_HOLD    = 80;

    typedef logic [7:0] t_frame [$];
    typedef enum {RX_OPEN, RX_CHOPPY, RX_STINGY} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fpfp_in_if  in_if ();
    fpfp_out_if out_if ();

    first_packet_frame_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (in_if),
        .o_result (out_if)
    );

    always #6 i_clk = ~i_clk;

    // frame parser state, mirrored
    int unsigned parse_pos   = 0;
    bit          stop_seen   = 1'b0;
    logic [7:0]  word_code   = '0;
    logic [31:0] word_value  = '0;
    t_fields     collected   = '0;
    t_fields     pending_headers [$];

    int error_count     = 0;
    int results_checked = 0;
    int bytes_sent      = 0;
    int frames_sent     = 0;
    int cycle_count     = 0;
    int gap_max         = 0;
    int burst_left      = 0;
    int hold_cycles_req = 0;

    task automatic predict_frame_byte(input logic [7:0] b, input logic last);
        int unsigned phase;
        if (parse_pos >= SRC_START && parse_pos < DST_START) begin
            collected.source_ip[8*(parse_pos-SRC_START) +: 8] = b;
        end else if (parse_pos >= DST_START && parse_pos < PORT_START) begin
            collected.dest_ip[8*(parse_pos-DST_START) +: 8] = b;
        end else if (parse_pos >= PORT_START && parse_pos < CODE_START) begin
            collected.dest_port[8*(parse_pos-PORT_START) +: 8] = b;
        end else if (parse_pos >= CODE_START && parse_pos < CMD_START) begin
            collected.command_code[8*(parse_pos-CODE_START) +: 8] = b;
        end else if (parse_pos >= CMD_START && parse_pos < CMD_END && !stop_seen) begin
            phase = (parse_pos - CMD_START) % WORD_BYTES;
            if (phase == 0) begin
                word_code  = b;
                word_value = '0;
                if (b == CODE_STOP) stop_seen = 1'b1;
            end else begin
                word_value[8*(phase-1) +: 8] = b;
                if (phase == WORD_BYTES - 1) begin
                    case (word_code)
                        CODE_SERIAL: collected.serial_number     = word_value;
                        CODE_TIME:   collected.first_packet_time = word_value;
                        CODE_ROUTE:  collected.route_ip          = word_value;
                        default: ;
                    endcase
                end
            end
        end
        if (parse_pos < CMD_END) parse_pos++;
        if (last) begin
            pending_headers.push_back(collected);
            parse_pos  = 0;
            stop_seen  = 1'b0;
            word_code  = '0;
            word_value = '0;
            collected  = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            predict_frame_byte(in_if.frame_byte, in_if.frame_end);
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_fields want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_headers.size() == 0) begin
                error_count++;
                $display("%0t: result transfer with no frame pending", $time);
            end else begin
                want = pending_headers.pop_front();
                results_checked++;
                check_field("source_ip", want.source_ip, out_if.source_ip);
                check_field("dest_ip", want.dest_ip, out_if.dest_ip);
                check_field("dest_port", 32'(want.dest_port), 32'(out_if.dest_port));
                check_field("command_code", 32'(want.command_code),
                            32'(out_if.command_code));
                check_field("serial_number", want.serial_number, out_if.serial_number);
                check_field("instrument_type", 32'(want.serial_number[1:0]),
                            32'(out_if.instrument_type));
                check_field("first_packet_time", want.first_packet_time,
                            out_if.first_packet_time);
                check_field("route_ip", want.route_ip, out_if.route_ip);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_headers.size());
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall pattern, plus a counted long hold on request
    initial begin : receiver
        int       hold_left;
        int       mode_left;
        t_rx_mode rx_mode;
        hold_left = 0;
        mode_left = 0;
        rx_mode   = RX_OPEN;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles_req > 0) begin
                hold_left       = hold_cycles_req;
                hold_cycles_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 120);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   out_if.ready <= 1'b1;
                    RX_CHOPPY: out_if.ready <= 1'($urandom_range(0, 1));
                    RX_STINGY: out_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_if.ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (gap_max > 0 && burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        in_if.valid      <= 1'b1;
        in_if.frame_byte <= b;
        in_if.frame_end  <= last;
        do @(posedge i_clk); while (!in_if.ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_frame f);
        foreach (f[i]) send_byte(f[i], i == f.size() - 1);
        frames_sent++;
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_headers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic void push_le(ref t_frame f, input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) f.push_back(v[8*i +: 8]);
    endfunction

    function automatic void push_header(ref t_frame f, input logic [31:0] src,
                                        input logic [31:0] dst, input logic [15:0] port,
                                        input logic [15:0] cmd);
        repeat (SRC_START) f.push_back(8'($urandom_range(0, 255)));
        push_le(f, src, 4);
        push_le(f, dst, 4);
        push_le(f, 32'(port), 2);
        push_le(f, 32'(cmd), 2);
    endfunction

    function automatic void push_word(ref t_frame f, input logic [7:0] code,
                                      input logic [31:0] value);
        f.push_back(code);
        push_le(f, value, 4);
    endfunction

    function automatic logic [7:0] pick_command_code();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 19);
        if (r < 2) return CODE_STOP;
        if (r < 7) return CODE_SERIAL;
        if (r < 12) return CODE_TIME;
        if (r < 16) return CODE_ROUTE;
        do c = 8'($urandom_range(3, 255)); while (c == CODE_ROUTE);
        return c;
    endfunction

    task automatic test_short_frames();
        t_frame f;
        gap_max = 0;
        f = {8'hFF};
        send_frame(f);
        f = {8'h00};
        send_frame(f);
        f.delete();
        push_header(f, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        while (f.size() > SRC_START + 2) void'(f.pop_back());
        send_frame(f);
        f.delete();
        push_header(f, 32'hA5A5_5A5A, 32'h0102_0304, 16'hFFFF, 16'h8001);
        while (f.size() > PORT_START + 1) void'(f.pop_back());
        send_frame(f);
        wait_for_results();
    endtask

    task automatic test_command_words();
        t_frame f;
        gap_max = 4;
        // serial, time, route and an unknown code, last word completes on the frame's last byte
        push_header(f, 32'h0A00_0001, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
        push_word(f, CODE_SERIAL, 32'hFFFF_FFFF);
        push_word(f, CODE_TIME, 32'h8000_0001);
        push_word(f, CODE_ROUTE, 32'hC0A8_0101);
        push_word(f, 8'hFF, 32'h1234_5678);
        send_frame(f);
        // repeated serial, then a time word cut short
        f.delete();
        push_header(f, 32'h0000_0000, 32'h7F00_0001, 16'h1F90, 16'h0001);
        push_word(f, CODE_SERIAL, 32'h1111_1112);
        push_word(f, CODE_SERIAL, 32'h7FFF_FFFD);
        push_word(f, CODE_TIME, 32'hDEAD_BEEF);
        repeat (2) void'(f.pop_back());
        send_frame(f);
        wait_for_results();
    endtask

    task automatic test_stop_code_and_long_frame();
        t_frame f;
        gap_max = 3;
        push_header(f, 32'h0102_0304, 32'h0506_0708, 16'h0909, 16'h0A0B);
        push_word(f, CODE_ROUTE, 32'hFFFF_FFFF);
        push_word(f, CODE_STOP, 32'hFFFF_FFFF);
        push_word(f, CODE_SERIAL, 32'h0000_0003);
        push_word(f, CODE_TIME, 32'h0000_0042);
        repeat (12) f.push_back(8'hFF);
        send_frame(f);
        // no stop code, words beyond the command area are dropped
        f.delete();
        push_header(f, 32'h0, 32'h0, 16'h0, 16'h0);
        repeat (MAX_COMMAND_WORDS) push_word(f, CODE_TIME, $urandom);
        push_word(f, CODE_SERIAL, 32'hFFFF_FFFF);
        push_word(f, CODE_ROUTE, 32'hFFFF_FFFF);
        send_frame(f);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        t_frame f;
        gap_max = 0;
        hold_cycles_req = LONG_HOLD;
        repeat (20) begin
            f = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
            send_frame(f);
        end
        wait_for_results();
    endtask

    task automatic test_random_frames();
        t_frame f;
        int     kind;
        int     cut;
        int     rnd_bytes;
        int     rnd_frames;
        rnd_bytes  = 0;
        rnd_frames = 0;
        while (rnd_bytes < RANDOM_BYTES || rnd_frames < MIN_FRAMES) begin
            f.delete();
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 60)) f.push_back(8'($urandom_range(0, 255)));
            end else begin
                push_header(f, $urandom, $urandom, 16'($urandom), 16'($urandom));
                repeat ($urandom_range(0, 6)) push_word(f, pick_command_code(), $urandom);
                repeat ($urandom_range(0, 6)) f.push_back(8'($urandom_range(0, 255)));
                if (kind == 1) begin
                    cut = $urandom_range(1, f.size());
                    while (f.size() > cut) void'(f.pop_back());
                end
            end
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            send_frame(f);
            rnd_bytes += f.size();
            rnd_frames++;
            if ($urandom_range(0, 15) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.frame_byte <= '0;
        in_if.frame_end  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_frames();
        test_command_words();
        test_stop_code_and_long_frame();
        test_backpressure();
        test_random_frames();

        $display("frames sent %0d, bytes transferred %0d, results checked %0d",
                 frames_sent, bytes_sent, results_checked);
        $display("short, partial, repeated, stopped and overlong frames under stalls; %0d errors",
                 error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- first_packet_frame_parser.f -----
sv/fpfp_pkg.sv
sv/fpfp_in_if.sv
sv/fpfp_out_if.sv
sv/fpfp_parse.sv
sv/first_packet_frame_parser.sv
bench/tb_first_packet_frame_parser.sv
